FILE: design/rsc_pkg.sv
`timescale 1ns / 1ps
package rsc_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int MAX_RESULTS     = 32;
   localparam int DATA_W          = 32;

   typedef enum logic [3:0] {
      FN_PUSH = 4'd0,
      FN_ADD  = 4'd1,
      FN_SUB  = 4'd2,
      FN_MUL  = 4'd3,
      FN_DIV  = 4'd4,
      FN_OR   = 4'd5,
      FN_POW  = 4'd6,
      FN_TOP  = 4'd7,
      FN_DUMP = 4'd8,
      FN_WIPE = 4'd9
   } func_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_SMALL   = 3'd1,
      ST_DIVZERO = 3'd2,
      ST_FULL    = 3'd3,
      ST_NEGEXP  = 3'd4,
      ST_UNKNOWN = 3'd5
   } status_type;

   typedef struct packed {
      logic [3:0]  func;
      logic [30:0] operand;
   } req_word_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] result_value;
      logic               value_valid;
      logic               last;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_B,
      S_RD_A,
      S_CHECK,
      S_MUL,
      S_DIV,
      S_POW,
      S_WRITE,
      S_DUMP_RD,
      S_DUMP_OUT,
      S_RESP
   } state_type;

   // ALU operation selected for the arithmetic step
   typedef enum logic [1:0] {
      AOP_NONE,
      AOP_MUL,
      AOP_DIV,
      AOP_POW
   } aop_type;

   // controller to datapath
   typedef struct packed {
      logic       latch_req;
      logic       rd_b;
      logic       rd_a;
      logic       cap_b;
      logic       cap_a;
      logic       start_mul;
      logic       start_div;
      logic       start_pow;
      logic       do_simple;
      logic       wr_push;
      logic       wr_result;
      logic       wipe;
      logic       dump_rd;
      logic       dump_adv;
      logic       load_rsp;
      logic [2:0] rsp_status;
      logic       rsp_vv;
      logic       rsp_last;
      logic       rsp_from_b;
      logic       rsp_from_rd;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic [3:0] func;
      logic       count_lt1;
      logic       count_lt2;
      logic       count_full;
      logic       b_zero;
      logic       b_neg;
      logic       alu_done;
      logic       dump_last;
      logic       rsp_busy;
   } sts_type;

endpackage

FILE: design/rsc_ram.sv
`timescale 1ns / 1ps
module rsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rsc_ctrl.sv
`timescale 1ns / 1ps
module rsc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rsc_pkg::sts_type         sts,
   output rsc_pkg::ctl_type         ctl
);

   rsc_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rsc_pkg::S_IDLE: begin
            if (req_valid) state_in = rsc_pkg::S_RD_B;
         end
         rsc_pkg::S_RD_B: state_in = rsc_pkg::S_RD_A;
         rsc_pkg::S_RD_A: state_in = rsc_pkg::S_CHECK;
         rsc_pkg::S_CHECK: begin
            if (!sts.rsp_busy) begin
               case (sts.func)
                  rsc_pkg::FN_ADD, rsc_pkg::FN_SUB, rsc_pkg::FN_OR: begin
                     state_in = sts.count_lt2 ? rsc_pkg::S_IDLE : rsc_pkg::S_WRITE;
                  end
                  rsc_pkg::FN_MUL: begin
                     state_in = sts.count_lt2 ? rsc_pkg::S_IDLE : rsc_pkg::S_MUL;
                  end
                  rsc_pkg::FN_DIV: begin
                     state_in = (sts.count_lt2 || sts.b_zero) ? rsc_pkg::S_IDLE
                                                              : rsc_pkg::S_DIV;
                  end
                  rsc_pkg::FN_POW: begin
                     state_in = (sts.count_lt2 || sts.b_neg) ? rsc_pkg::S_IDLE
                                                             : rsc_pkg::S_POW;
                  end
                  rsc_pkg::FN_DUMP: begin
                     state_in = sts.count_lt1 ? rsc_pkg::S_IDLE : rsc_pkg::S_DUMP_RD;
                  end
                  default: state_in = rsc_pkg::S_IDLE;
               endcase
            end
         end
         rsc_pkg::S_MUL, rsc_pkg::S_DIV, rsc_pkg::S_POW: begin
            if (sts.alu_done) state_in = rsc_pkg::S_WRITE;
         end
         rsc_pkg::S_WRITE: begin
            if (!sts.rsp_busy) state_in = rsc_pkg::S_IDLE;
         end
         rsc_pkg::S_DUMP_RD: state_in = rsc_pkg::S_RESP;
         rsc_pkg::S_RESP: state_in = rsc_pkg::S_DUMP_OUT;
         rsc_pkg::S_DUMP_OUT: begin
            if (!sts.rsp_busy) begin
               state_in = sts.dump_last ? rsc_pkg::S_IDLE : rsc_pkg::S_DUMP_RD;
            end
         end
         default: state_in = rsc_pkg::S_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      ctl = '0;
      req_stall = 1'b1;
      case (state_ff)
         rsc_pkg::S_IDLE: begin
            req_stall = 1'b0;
            ctl.latch_req = req_valid;
         end
         rsc_pkg::S_RD_B: ctl.rd_b = 1'b1;
         rsc_pkg::S_RD_A: begin
            ctl.rd_a  = 1'b1;
            ctl.cap_b = 1'b1;
         end
         rsc_pkg::S_CHECK: begin
            // hold the left operand address while the response waits
            ctl.rd_a        = 1'b1;
            ctl.cap_a       = 1'b1;
            ctl.rsp_last    = 1'b1;
            ctl.rsp_status  = rsc_pkg::ST_OK;
            if (!sts.rsp_busy) begin
               case (sts.func)
                  rsc_pkg::FN_PUSH: begin
                     ctl.load_rsp = 1'b1;
                     if (sts.count_full) begin
                        ctl.rsp_status = rsc_pkg::ST_FULL;
                     end else begin
                        ctl.wr_push = 1'b1;
                     end
                  end
                  rsc_pkg::FN_ADD, rsc_pkg::FN_SUB, rsc_pkg::FN_OR: begin
                     if (sts.count_lt2) begin
                        ctl.load_rsp   = 1'b1;
                        ctl.rsp_status = rsc_pkg::ST_SMALL;
                     end else begin
                        ctl.do_simple = 1'b1;
                     end
                  end
                  rsc_pkg::FN_MUL: begin
                     if (sts.count_lt2) begin
                        ctl.load_rsp   = 1'b1;
                        ctl.rsp_status = rsc_pkg::ST_SMALL;
                     end else begin
                        ctl.start_mul = 1'b1;
                     end
                  end
                  rsc_pkg::FN_DIV: begin
                     if (sts.count_lt2) begin
                        ctl.load_rsp   = 1'b1;
                        ctl.rsp_status = rsc_pkg::ST_SMALL;
                     end else if (sts.b_zero) begin
                        ctl.load_rsp   = 1'b1;
                        ctl.rsp_status = rsc_pkg::ST_DIVZERO;
                     end else begin
                        ctl.start_div = 1'b1;
                     end
                  end
                  rsc_pkg::FN_POW: begin
                     if (sts.count_lt2) begin
                        ctl.load_rsp   = 1'b1;
                        ctl.rsp_status = rsc_pkg::ST_SMALL;
                     end else if (sts.b_neg) begin
                        ctl.load_rsp   = 1'b1;
                        ctl.rsp_status = rsc_pkg::ST_NEGEXP;
                     end else begin
                        ctl.start_pow = 1'b1;
                     end
                  end
                  rsc_pkg::FN_TOP: begin
                     ctl.load_rsp = 1'b1;
                     if (sts.count_lt1) begin
                        ctl.rsp_status = rsc_pkg::ST_SMALL;
                     end else begin
                        ctl.rsp_vv     = 1'b1;
                        ctl.rsp_from_b = 1'b1;
                     end
                  end
                  rsc_pkg::FN_DUMP: begin
                     ctl.load_rsp = sts.count_lt1;
                  end
                  rsc_pkg::FN_WIPE: begin
                     ctl.load_rsp = 1'b1;
                     ctl.wipe     = 1'b1;
                  end
                  default: begin
                     ctl.load_rsp   = 1'b1;
                     ctl.rsp_status = rsc_pkg::ST_UNKNOWN;
                  end
               endcase
            end
         end
         rsc_pkg::S_MUL, rsc_pkg::S_DIV, rsc_pkg::S_POW: begin
         end
         rsc_pkg::S_WRITE: begin
            ctl.rsp_last   = 1'b1;
            ctl.rsp_status = rsc_pkg::ST_OK;
            if (!sts.rsp_busy) begin
               ctl.wr_result = 1'b1;
               ctl.load_rsp  = 1'b1;
            end
         end
         rsc_pkg::S_DUMP_RD: ctl.dump_rd = 1'b1;
         rsc_pkg::S_RESP: ctl.dump_rd = 1'b1;
         rsc_pkg::S_DUMP_OUT: begin
            ctl.dump_rd     = 1'b1;
            ctl.rsp_status  = rsc_pkg::ST_OK;
            ctl.rsp_vv      = 1'b1;
            ctl.rsp_from_rd = 1'b1;
            ctl.rsp_last    = sts.dump_last;
            if (!sts.rsp_busy) begin
               ctl.load_rsp = 1'b1;
               ctl.dump_adv = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a word is taken only in idle
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> state_ff == rsc_pkg::S_IDLE)
      else $error("request taken outside idle");
   // a push and a result write never target the stack together
   assert property (@(posedge clock) disable iff (reset)
      !(ctl.wr_push && ctl.wr_result))
      else $error("double stack write");
   // an arithmetic unit runs only after an operand check
   assert property (@(posedge clock) disable iff (reset)
      (ctl.start_mul || ctl.start_div || ctl.start_pow) |=>
      (state_ff == rsc_pkg::S_MUL || state_ff == rsc_pkg::S_DIV ||
       state_ff == rsc_pkg::S_POW))
      else $error("unit started without its wait state");

endmodule

FILE: design/rsc_dpath.sv
`timescale 1ns / 1ps
module rsc_dpath #(
   parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rsc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsc_pkg::rsp_word_type rsp_word,
   input  rsc_pkg::ctl_type      ctl,
   output rsc_pkg::sts_type      sts
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int DW = rsc_pkg::DATA_W;
   localparam int NR = (STACK_DEPTH < rsc_pkg::MAX_RESULTS) ? STACK_DEPTH
                                                           : rsc_pkg::MAX_RESULTS;
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] NR_C    = CW'(NR);

   logic [3:0]    func_ff;
   logic [30:0]   operand_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [DW-1:0] a_ff, b_ff;
   logic [DW-1:0] a_op;
   logic [DW-1:0] res_ff, res_in;
   logic [CW-1:0] dptr_ff, dptr_in;
   logic [CW-1:0] dlim;
   rsc_pkg::rsp_word_type rsp_ff;
   logic          rsp_valid_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [DW-1:0] wr_data, rd_data;

   // iterative unit state
   rsc_pkg::aop_type aop_ff;
   logic          busy_ff;
   logic [5:0]    step_ff;
   logic [DW-1:0] acc_ff;      // product / quotient / power result
   logic [DW-1:0] x_ff;        // divisor / base
   logic [DW-1:0] y_ff;        // dividend bits / exponent
   logic [DW-1:0] rem_ff;
   logic          qneg_ff;
   logic          pow_phase_ff; // 0: multiply result, 1: square base
   logic [DW-1:0] pm_acc_ff, pm_x_ff, pm_y_ff;
   logic          pm_busy_ff;
   logic          alu_done;

   rsc_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // stack read address per step
   always_comb begin
      rd_addr = '0;
      if (ctl.rd_b) rd_addr = AW'(count_ff - CW'(1));
      if (ctl.rd_a) rd_addr = AW'(count_ff - CW'(2));
      if (ctl.dump_rd) rd_addr = AW'(dptr_ff);
   end

   // left operand straight from the read port while it is being captured
   assign a_op = ctl.cap_a ? rd_data : a_ff;

   // stack write: push at count, result over left operand
   always_comb begin
      wr_en   = ctl.wr_push || ctl.wr_result;
      wr_addr = ctl.wr_push ? AW'(count_ff) : AW'(count_ff - CW'(2));
      wr_data = ctl.wr_push ? {1'b0, operand_ff} : res_ff;
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.wr_push)   count_in = count_ff + CW'(1);
      if (ctl.wr_result) count_in = count_ff - CW'(1);
      if (ctl.wipe)      count_in = '0;
   end

   always_comb begin
      dlim    = (count_ff > NR_C) ? NR_C : count_ff;
      dptr_in = dptr_ff;
      if (ctl.latch_req) dptr_in = '0;
      if (ctl.dump_adv)  dptr_in = dptr_ff + CW'(1);
   end

   // add, sub and or in one step; an iterative result is loaded on alu_done
   always_comb begin
      res_in = res_ff;
      if (ctl.do_simple) begin
         case (func_ff)
            rsc_pkg::FN_ADD: res_in = a_op + b_ff;
            rsc_pkg::FN_SUB: res_in = a_op - b_ff;
            default:         res_in = a_op | b_ff;
         endcase
      end else if (alu_done) begin
         res_in = (aop_ff == rsc_pkg::AOP_DIV && qneg_ff) ? (DW'(0) - acc_ff) : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         dptr_ff  <= '0;
      end else begin
         count_ff <= count_in;
         dptr_ff  <= dptr_in;
      end
      if (ctl.latch_req) begin
         func_ff    <= req_word.func;
         operand_ff <= req_word.operand;
      end
      if (ctl.cap_b) b_ff <= rd_data;
      if (ctl.cap_a) a_ff <= rd_data;
      res_ff <= res_in;
   end

   // shift-add multiply, restoring divide, square-and-multiply power:
   // one bit (or one shift-add) per cycle
   logic [DW-1:0] am, bm;
   always_comb begin
      am = a_op[DW-1] ? (DW'(0) - a_op) : a_op;
      bm = b_ff[DW-1] ? (DW'(0) - b_ff) : b_ff;
   end

   logic [DW:0]   rem_sh;
   logic [DW:0]   rem_sub;
   always_comb begin
      rem_sh  = {rem_ff, y_ff[DW-1]};
      rem_sub = rem_sh - {1'b0, x_ff};
   end

   // inner shift-add multiplier shared by mul and pow
   logic [DW-1:0] pm_acc_in;
   always_comb begin
      pm_acc_in = pm_y_ff[0] ? (pm_acc_ff + pm_x_ff) : pm_acc_ff;
   end

   assign alu_done = busy_ff && step_ff == 6'd0 && !pm_busy_ff &&
                     (aop_ff == rsc_pkg::AOP_DIV || aop_ff == rsc_pkg::AOP_MUL ||
                      (aop_ff == rsc_pkg::AOP_POW && y_ff == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         pm_busy_ff <= 1'b0;
         aop_ff     <= rsc_pkg::AOP_NONE;
      end else if (ctl.start_mul) begin
         busy_ff    <= 1'b1;
         aop_ff     <= rsc_pkg::AOP_MUL;
         pm_busy_ff <= 1'b1;
         pm_acc_ff  <= '0;
         pm_x_ff    <= a_op;
         pm_y_ff    <= b_ff;
         step_ff    <= 6'd0;
      end else if (ctl.start_div) begin
         busy_ff <= 1'b1;
         aop_ff  <= rsc_pkg::AOP_DIV;
         x_ff    <= bm;
         y_ff    <= am;
         rem_ff  <= '0;
         acc_ff  <= '0;
         qneg_ff <= a_op[DW-1] ^ b_ff[DW-1];
         step_ff <= 6'(DW);
      end else if (ctl.start_pow) begin
         busy_ff      <= 1'b1;
         aop_ff       <= rsc_pkg::AOP_POW;
         acc_ff       <= DW'(1);
         x_ff         <= a_op;
         y_ff         <= b_ff;
         pow_phase_ff <= 1'b0;
         step_ff      <= 6'd0;
      end else if (busy_ff) begin
         if (pm_busy_ff) begin
            // one shift-add step of the inner multiplier
            pm_acc_ff <= pm_acc_in;
            pm_x_ff   <= pm_x_ff << 1;
            pm_y_ff   <= pm_y_ff >> 1;
            if ((pm_y_ff >> 1) == '0) begin
               pm_busy_ff <= 1'b0;
               case (aop_ff)
                  rsc_pkg::AOP_MUL: acc_ff <= pm_acc_in;
                  rsc_pkg::AOP_POW: begin
                     if (pow_phase_ff) begin
                        // square done: advance to the next exponent bit
                        x_ff         <= pm_acc_in;
                        y_ff         <= y_ff >> 1;
                        pow_phase_ff <= 1'b0;
                     end else begin
                        // result multiply done: the square follows
                        acc_ff       <= pm_acc_in;
                        pow_phase_ff <= 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end else if (alu_done) begin
            busy_ff <= 1'b0;
            aop_ff  <= rsc_pkg::AOP_NONE;
         end else if (aop_ff == rsc_pkg::AOP_DIV) begin
            // restoring divide, one quotient bit
            y_ff <= y_ff << 1;
            if (!rem_sub[DW]) begin
               rem_ff <= rem_sub[DW-1:0];
               acc_ff <= {acc_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[DW-1:0];
               acc_ff <= {acc_ff[DW-2:0], 1'b0};
            end
            step_ff <= step_ff - 6'd1;
         end else if (aop_ff == rsc_pkg::AOP_POW) begin
            // multiply result by base when the exponent bit is set, else square
            pm_busy_ff <= 1'b1;
            pm_acc_ff  <= '0;
            if (!pow_phase_ff && y_ff[0]) begin
               pm_x_ff <= acc_ff;
               pm_y_ff <= x_ff;
            end else begin
               pm_x_ff      <= x_ff;
               pm_y_ff      <= x_ff;
               pow_phase_ff <= 1'b1;
            end
         end
      end
   end

   // response register
   logic rsp_take;
   assign rsp_take = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_valid_ff <= 1'b0;
      end
      if (ctl.load_rsp) begin
         rsp_ff.status       <= ctl.rsp_status;
         rsp_ff.value_valid  <= ctl.rsp_vv;
         rsp_ff.last         <= ctl.rsp_last;
         rsp_ff.result_value <= ctl.rsp_from_b  ? b_ff :
                                ctl.rsp_from_rd ? rd_data : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      sts.func       = func_ff;
      sts.count_lt1  = count_ff == '0;
      sts.count_lt2  = count_ff < CW'(2);
      sts.count_full = count_ff >= DEPTH_C;
      sts.b_zero     = b_ff == '0;
      sts.b_neg      = b_ff[DW-1];
      sts.alu_done   = alu_done;
      sts.dump_last  = (dptr_ff + CW'(1)) == dlim;
      sts.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   // the stack never holds more than its depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_C)
      else $error("entry count beyond depth");
   // a response is never overwritten while it waits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !ctl.load_rsp)
      else $error("response overwritten");
   // a held response keeps its word
   assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid_ff && rsp_stall) |-> $stable(rsp_ff))
      else $error("stalled response changed");

endmodule

FILE: design/rpn_stack_calculator.sv
`timescale 1ns / 1ps
// RPN calculator over a stack of 32-bit entries held in a RAM with one
// write port and one registered read port. One command word is taken at
// a time. Push, wipe, top and refused commands finish in the check state;
// add, sub and or then write their result. Multiply runs a shift-add loop;
// divide runs a restoring loop at one quotient bit per cycle; power runs
// one inner shift-add multiply for each set exponent bit and each square.
// Dump gives one response word per entry, up to MAX_RESULTS, bottom first.
// The stack RAM needs no clearing after reset.
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rsc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsc_pkg::rsp_word_type rsp_word
);

   rsc_pkg::ctl_type ctl;
   rsc_pkg::sts_type sts;

   rsc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .ctl      (ctl)
   );

   rsc_dpath #(.STACK_DEPTH(STACK_DEPTH)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word),
      .ctl      (ctl),
      .sts      (sts)
   );

endmodule
